// ===== rtl/cpo_pkg.sv =====
`default_nettype none

package cpo_pkg;

  localparam int COORD_W = 24;
  localparam int WIDTH_W = 24;
  localparam int IDX_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int UNIT_W  = 17;

  localparam logic [CFG_IDX_W-1:0] REG_OUTER_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_WIDTH = 2'd1;

  localparam logic [UNIT_W-1:0] UNIT_ONE = 17'd65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  // c plus or minus an unsigned offset magnitude, clamped to the coordinate range
  function automatic logic signed [COORD_W-1:0] add_sat(
    input logic signed [COORD_W-1:0] c,
    input logic [COORD_W:0] mag,
    input logic sub
  );
    logic signed [COORD_W+2:0] ce;
    logic signed [COORD_W+2:0] me;
    logic signed [COORD_W+2:0] v;
    ce = {{3{c[COORD_W-1]}}, c};
    me = {2'b00, mag};
    v = sub ? (ce - me) : (ce + me);
    if (v > 27'sd8388607) begin
      add_sat = 24'sh7fffff;
    end else if (v < -27'sd8388608) begin
      add_sat = 24'sh800000;
    end else begin
      add_sat = v[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/closed_polyline_offset.sv =====
`default_nettype none
// Offsets a closed centerline to an outer and an inner boundary.
// Points enter on the in channel (point_x, point_y, end_of_track), one beat per
// point. Results leave on the out channel, tagged with point_index. The result
// for point k leaves once point k+1 has arrived; the beat with end_of_track
// releases the last point and then point 0, which carries run_done. A track of
// one point gives a single beat with too_short set and zero coordinates.
// Widths are written on the cfg channel (index 0 outer, 1 inner), accepted
// every cycle; other indexes are dropped.
// Each result is worked out by one shared 24x24 multiplier, a square root that
// settles one root bit per cycle and a divider that settles one quotient bit
// per cycle for each component; the root and divisions are skipped when the
// tangent is zero. An item that only loads the loop leaves in_ready high; other
// items take one to three results, and in_ready stays low meanwhile.
// A stalled receiver holds the result register and the sequencer waits on it.
// Reset (rst, synchronous) clears both widths, the track phase, the point count
// and out_valid; the next beat starts a new track.
module closed_polyline_offset import cpo_pkg::*; #(
  parameter int MAX_POINTS = 65536
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [WIDTH_W-1:0]          cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [COORD_W-1:0]   point_x,
  input  wire logic signed [COORD_W-1:0]   point_y,
  input  wire logic                        end_of_track,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [IDX_W-1:0]                 point_index,
  output logic signed [COORD_W-1:0]        outer_x,
  output logic signed [COORD_W-1:0]        outer_y,
  output logic signed [COORD_W-1:0]        inner_x,
  output logic signed [COORD_W-1:0]        inner_y,
  output logic                             too_short,
  output logic                             run_done
);

  localparam int CNT_W = $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_POINTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_SQX, S_SQY, S_SUM, S_SQRT, S_DIVX, S_DIVY, S_MUL, S_OUT
  } state_t;

  typedef enum logic [1:0] {J_PREV, J_LAST, J_FIRST, J_SHORT} job_t;
  typedef enum logic [1:0] {PH_EMPTY, PH_ONE, PH_MANY} phase_t;

  state_t state;
  job_t   job;
  phase_t phase;

  logic [WIDTH_W-1:0] outer_width;
  logic [WIDTH_W-1:0] inner_width;
  point_t first_pt, second_pt, older_pt, prior_pt, cur_pt;
  logic cur_last;
  logic [CNT_W-1:0] point_count;
  logic [CNT_W-1:0] count_prev;
  logic [CNT_W-1:0] count_next;

  // per-result working registers
  point_t cen;
  logic [IDX_W-1:0] jidx;
  logic jdone;
  logic [COORD_W-1:0] tmx, tmy;
  logic tnx, tny;
  logic [2*COORD_W-1:0] prod;
  logic [49:0] sumsq;
  logic [63:0] rad;
  logic [34:0] srem;
  logic [31:0] root;
  logic [4:0] itc;
  logic [47:0] drem;
  logic [47:0] dsh;
  logic [UNIT_W-1:0] quo;
  logic [UNIT_W-1:0] ux_mag, uy_mag;
  logic [2:0] mi;
  logic [COORD_W:0] off_ox, off_oy, off_ix, off_iy;

  // combinational helpers
  logic [COORD_W-1:0] mul_a, mul_b;
  logic [COORD_W:0] rnd;
  logic [49:0] sum_full;
  logic [34:0] sq_shift;
  logic [34:0] sq_trial;
  logic sq_ge;
  logic [31:0] root_next;
  logic dv_ge;
  logic [UNIT_W-1:0] quo_next;
  logic [UNIT_W-1:0] quo_clamp;
  point_t sel_c, sel_prev, sel_next;
  logic signed [COORD_W:0] dx, dy;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign count_prev = (point_count == '0) ? CNT_LAST : point_count - 1'b1;
  assign count_next = (point_count == CNT_LAST) ? '0 : point_count + 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin
        mul_a = tmx;
        mul_b = tmx;
      end
      S_SQY: begin
        mul_a = tmy;
        mul_b = tmy;
      end
      S_MUL: begin
        case (mi)
          3'd0: begin
            mul_a = COORD_W'(uy_mag);
            mul_b = outer_width;
          end
          3'd1: begin
            mul_a = COORD_W'(ux_mag);
            mul_b = outer_width;
          end
          3'd2: begin
            mul_a = COORD_W'(uy_mag);
            mul_b = inner_width;
          end
          3'd3: begin
            mul_a = COORD_W'(ux_mag);
            mul_b = inner_width;
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rnd = (COORD_W+1)'((prod + 48'd32768) >> 16);
  assign sum_full = sumsq + 50'(prod);

  // one root bit per cycle
  assign sq_shift  = {srem[32:0], rad[63:62]};
  assign sq_trial  = {1'b0, root, 2'b01};
  assign sq_ge     = (sq_shift >= sq_trial);
  assign root_next = {root[30:0], sq_ge};

  // one quotient bit per cycle
  assign dv_ge     = (drem >= dsh);
  assign quo_next  = {quo[UNIT_W-2:0], dv_ge};
  assign quo_clamp = (quo_next > UNIT_ONE) ? UNIT_ONE : quo_next;

  always_comb begin
    case (job)
      J_PREV: begin
        sel_c = prior_pt;
        sel_prev = older_pt;
        sel_next = cur_pt;
      end
      J_LAST: begin
        sel_c = cur_pt;
        sel_prev = prior_pt;
        sel_next = first_pt;
      end
      default: begin
        sel_c = first_pt;
        sel_prev = cur_pt;
        sel_next = second_pt;
      end
    endcase
  end

  assign dx = {sel_next.x[COORD_W-1], sel_next.x} - {sel_prev.x[COORD_W-1], sel_prev.x};
  assign dy = {sel_next.y[COORD_W-1], sel_next.y} - {sel_prev.y[COORD_W-1], sel_prev.y};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job <= J_PREV;
      phase <= PH_EMPTY;
      point_count <= '0;
      outer_width <= '0;
      inner_width <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OUTER_WIDTH: outer_width <= cfg_data;
          REG_INNER_WIDTH: inner_width <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      prod <= mul_a * mul_b;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_pt <= '{x: point_x, y: point_y};
            cur_last <= end_of_track;
            case (phase)
              PH_EMPTY: begin
                if (end_of_track) begin
                  job <= J_SHORT;
                  state <= S_OUT;
                end else begin
                  first_pt <= '{x: point_x, y: point_y};
                  prior_pt <= '{x: point_x, y: point_y};
                  phase <= PH_ONE;
                  point_count <= count_next;
                end
              end
              PH_ONE: begin
                second_pt <= '{x: point_x, y: point_y};
                if (end_of_track) begin
                  job <= J_LAST;
                  state <= S_SETUP;
                end else begin
                  older_pt <= prior_pt;
                  prior_pt <= '{x: point_x, y: point_y};
                  phase <= PH_MANY;
                  point_count <= count_next;
                end
              end
              default: begin
                job <= J_PREV;
                state <= S_SETUP;
              end
            endcase
          end
        end

        S_SETUP: begin
          cen <= sel_c;
          case (job)
            J_PREV: jidx <= IDX_W'(count_prev);
            J_LAST: jidx <= IDX_W'(point_count);
            default: jidx <= '0;
          endcase
          jdone <= (job == J_FIRST);
          tnx <= dx[COORD_W];
          tny <= dy[COORD_W];
          tmx <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
          tmy <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
          state <= S_SQX;
        end

        S_SQX: begin
          state <= S_SQY;
        end

        S_SQY: begin
          sumsq <= 50'(prod);
          state <= S_SUM;
        end

        S_SUM: begin
          if (sum_full == '0) begin
            ux_mag <= '0;
            uy_mag <= '0;
            mi <= '0;
            state <= S_MUL;
          end else begin
            rad <= {sum_full, 14'b0};
            srem <= '0;
            root <= '0;
            itc <= '0;
            state <= S_SQRT;
          end
        end

        S_SQRT: begin
          srem <= sq_ge ? (sq_shift - sq_trial) : sq_shift;
          root <= root_next;
          rad <= {rad[61:0], 2'b00};
          itc <= itc + 1'b1;
          if (itc == 5'd31) begin
            drem <= {1'b0, tmx, 23'b0} + 48'(root_next >> 1);
            dsh <= {root_next, 16'b0};
            quo <= '0;
            itc <= '0;
            state <= S_DIVX;
          end
        end

        S_DIVX: begin
          drem <= dv_ge ? (drem - dsh) : drem;
          dsh <= dsh >> 1;
          quo <= quo_next;
          itc <= itc + 1'b1;
          if (itc == 5'd16) begin
            ux_mag <= quo_clamp;
            drem <= {1'b0, tmy, 23'b0} + 48'(root >> 1);
            dsh <= {root, 16'b0};
            quo <= '0;
            itc <= '0;
            state <= S_DIVY;
          end
        end

        S_DIVY: begin
          drem <= dv_ge ? (drem - dsh) : drem;
          dsh <= dsh >> 1;
          quo <= quo_next;
          itc <= itc + 1'b1;
          if (itc == 5'd16) begin
            uy_mag <= quo_clamp;
            mi <= '0;
            state <= S_MUL;
          end
        end

        S_MUL: begin
          // product of step mi lands in prod on the next cycle
          mi <= mi + 1'b1;
          case (mi)
            3'd1: off_ox <= rnd;
            3'd2: off_oy <= rnd;
            3'd3: off_ix <= rnd;
            3'd4: off_iy <= rnd;
            default: ;
          endcase
          if (mi == 3'd4) begin
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (job == J_SHORT) begin
              point_index <= '0;
              outer_x <= '0;
              outer_y <= '0;
              inner_x <= '0;
              inner_y <= '0;
              too_short <= 1'b1;
              run_done <= 1'b1;
            end else begin
              point_index <= jidx;
              outer_x <= add_sat(cen.x, off_ox, !tny);
              outer_y <= add_sat(cen.y, off_oy, tnx);
              inner_x <= add_sat(cen.x, off_ix, tny);
              inner_y <= add_sat(cen.y, off_iy, !tnx);
              too_short <= 1'b0;
              run_done <= jdone;
            end
            case (job)
              J_PREV: begin
                if (cur_last) begin
                  job <= J_LAST;
                  state <= S_SETUP;
                end else begin
                  older_pt <= prior_pt;
                  prior_pt <= cur_pt;
                  point_count <= count_next;
                  state <= S_IDLE;
                end
              end
              J_LAST: begin
                job <= J_FIRST;
                state <= S_SETUP;
              end
              default: begin
                // track finished, start over
                phase <= PH_EMPTY;
                point_count <= '0;
                state <= S_IDLE;
              end
            endcase
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cpo_check.sv =====
`default_nettype none

module cpo_check import cpo_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [IDX_W-1:0]          point_index,
  input wire logic signed [COORD_W-1:0] outer_x,
  input wire logic signed [COORD_W-1:0] outer_y,
  input wire logic signed [COORD_W-1:0] inner_x,
  input wire logic signed [COORD_W-1:0] inner_y,
  input wire logic                      too_short,
  input wire logic                      run_done
);

  // a single-point track ends itself
  a_short_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> run_done)
    else $error("too_short beat without run_done");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> (point_index == '0) && (outer_x == '0) &&
      (outer_y == '0) && (inner_x == '0) && (inner_y == '0))
    else $error("too_short beat with nonzero payload");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_index) &&
      $stable(outer_x) && $stable(outer_y) && $stable(inner_x) && $stable(inner_y))
    else $error("stalled result beat changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind closed_polyline_offset cpo_check u_cpo_check (.*);

`default_nettype wire
